@@ rtl/core/mtg_pkg.sv @@
// shared constants and types of the mt19937 generator
package mtg_pkg;

  localparam int WORD_W  = 32;
  localparam int WORDS   = 624;
  localparam int SHIFT   = 397;
  localparam int INDEX_W = $clog2(WORDS);

  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX     = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

  // action codes of an input beat
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // selects what enters the tail of the cell chain
  typedef struct packed {
    logic               init_step;  // seeding walk in progress
    logic               load_seed;  // first word of a seed
    logic [INDEX_W-1:0] index;      // word index of the seeding walk
  } fb_ctrl_t;

endpackage

@@ rtl/core/mtg_if.sv @@
// handshake channels of the mt19937 generator
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed;

  modport source (output valid, output action, output seed, input ready);
  modport sink (input valid, input action, input seed, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ rtl/core/mtg_cell.sv @@
// one state word of the circular shift chain
module mtg_cell
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic [WORD_W-1:0] din,
  output logic [WORD_W-1:0] dout
);

  logic [WORD_W-1:0] word;

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (shift) begin
      word <= din;
    end
  end

  assign dout = word;

endmodule

@@ rtl/core/mtg_feedback.sv @@
// twist, seeding recurrence and tempering for the chain tail
module mtg_feedback
  import mtg_pkg::*;
(
  input  fb_ctrl_t          ctrl,
  input  logic [WORD_W-1:0] seed,
  input  logic [WORD_W-1:0] head,
  input  logic [WORD_W-1:0] next,
  input  logic [WORD_W-1:0] far,
  input  logic [WORD_W-1:0] tail,
  output logic [WORD_W-1:0] word_in,
  output logic [WORD_W-1:0] tempered
);

  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] twisted;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] init_word;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] t3;

  // twist of the word at the head
  assign y       = (head & UPPER_MASK) | (next & LOWER_MASK);
  assign twisted = far ^ (y >> 1) ^ (y[0] ? MATRIX : '0);

  // initialization recurrence from the last word written
  assign mix       = tail ^ (tail >> 30);
  assign init_word = (mix * INIT_MULT) + {{(WORD_W-INDEX_W){1'b0}}, ctrl.index};

  always_comb begin
    if (ctrl.init_step) begin
      word_in = init_word;
    end else if (ctrl.load_seed) begin
      word_in = seed;
    end else begin
      word_in = twisted;
    end
  end

  assign t1       = twisted ^ (twisted >> 11);
  assign t2       = t1 ^ ((t1 << 7) & TEMPER_B);
  assign t3       = t2 ^ ((t2 << 15) & TEMPER_C);
  assign tempered = t3 ^ (t3 >> 18);

endmodule

@@ rtl/core/mersenne_twister_generator.sv @@
// mt19937 generator top level: cell chain, seeding walk and result register
//
//  channel  dir   beat fields            meaning
//  cmd      in    action, seed           seed (action 0) or draw (action 1)
//  rnd      out   value                  tempered 32-bit number per draw
//
// a draw shifts the chain: the twisted word enters the chain tail and its
// tempered form goes to the result register; draws may follow back to back
// a seed walks the whole table: the seed word enters on the beat, then one
// multiply of the init recurrence per cycle for the other 623 words, while
// cmd.ready stays low
// reset clears all 624 cells to zero, so draws before a seed give zero
// a held result that rnd does not take this cycle stalls every cmd beat
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mtg_in_if.sink    cmd,
  mtg_out_if.source rnd
);

  // state words; cell 0 is the word at the read position
  logic [WORD_W-1:0] cell_q [WORDS];

  logic               seeding;
  logic [INDEX_W-1:0] seed_cnt;
  logic               out_valid;
  logic [WORD_W-1:0]  value;

  logic              accept;
  logic              draw;
  logic              shift;
  fb_ctrl_t          ctrl;
  logic [WORD_W-1:0] word_in;
  logic [WORD_W-1:0] tempered;

  // accept while not seeding and the result slot is free or draining
  assign cmd.ready = !seeding && (!out_valid || rnd.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign draw      = accept && (cmd.action == ACT_DRAW);
  assign shift     = accept || seeding;

  assign ctrl.init_step = seeding;
  assign ctrl.load_seed = accept && (cmd.action == ACT_SEED);
  assign ctrl.index     = seed_cnt;

  mtg_feedback u_feedback (
    .ctrl     (ctrl),
    .seed     (cmd.seed),
    .head     (cell_q[0]),
    .next     (cell_q[1]),
    .far      (cell_q[SHIFT]),
    .tail     (cell_q[WORDS-1]),
    .word_in  (word_in),
    .tempered (tempered)
  );

  // circular chain: each cell takes its right neighbor, the tail takes new data
  for (genvar i = 0; i < WORDS; i++) begin : g_cell
    logic [WORD_W-1:0] din;
    if (i == WORDS - 1) begin : g_tail
      assign din = word_in;
    end else begin : g_body
      assign din = cell_q[i+1];
    end
    mtg_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   (din),
      .dout  (cell_q[i])
    );
  end

  // seeding walk: words 1..623 follow the seed word
  always_ff @(posedge clk) begin
    if (rst) begin
      seeding  <= 1'b0;
      seed_cnt <= '0;
    end else if (seeding) begin
      if (seed_cnt == INDEX_W'(WORDS - 1)) begin
        seeding  <= 1'b0;
        seed_cnt <= '0;
      end else begin
        seed_cnt <= seed_cnt + 1'b1;
      end
    end else if (ctrl.load_seed) begin
      seeding  <= 1'b1;
      seed_cnt <= INDEX_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw) begin
      out_valid <= 1'b1;
    end else if (rnd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      value <= tempered;
    end
  end

  assign rnd.valid = out_valid;
  assign rnd.value = value;

  // no beat is taken during the seeding walk
  a_seed_blocks: assert property (@(posedge clk) disable iff (rst)
    seeding |-> !cmd.ready)
    else $error("input beat accepted during seeding");

  // a seed beat starts the walk at word one
  a_seed_start: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_seed |=> seeding && (seed_cnt == INDEX_W'(1)))
    else $error("seeding walk did not start");

  // the walk ends after the last word
  a_seed_end: assert property (@(posedge clk) disable iff (rst)
    seeding && (seed_cnt == INDEX_W'(WORDS - 1)) |=> !seeding)
    else $error("seeding walk overran");

  // a draw always presents a result next cycle
  a_draw_result: assert property (@(posedge clk) disable iff (rst)
    draw |=> out_valid)
    else $error("draw lost its result");

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the mt19937 generator
module tb;
  import mtg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int RAND_ITEMS   = 1730;    // random beats after the directed table
  localparam int HOLD_AT      = 700;     // cmd beat count that starts the long rnd stall
  localparam int HOLD_CYCLES  = 400;     // length of that stall
  localparam int PAUSE_AT     = 1300;    // cmd beat count after which cmd waits for a drain
  localparam int DRAIN_CYCLES = 50;      // quiet time after the last expected value
  localparam int CYCLE_LIMIT  = 500000;  // generous ceiling on the whole run

  // the usual default seed of the published generator
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd5489;

  // one row of the directed table; want is only used where typed is set
  typedef struct packed {
    logic              act;
    logic [WORD_W-1:0] sd;
    logic              typed;
    logic [WORD_W-1:0] want;
  } plan_row_t;

  localparam int PLAN_ROWS = 20;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // before any seed the table is all zeros, so draws give zero
    '{ACT_DRAW, 32'h0000_0000, 1'b1, 32'h0000_0000},
    // the seed field of a draw is ignored
    '{ACT_DRAW, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ACT_DRAW, 32'h1234_5678, 1'b1, 32'h0000_0000},
    // smallest seed
    '{ACT_SEED, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    // largest seed
    '{ACT_SEED, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_SEED, SEED_DEFAULT,  1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    // seed right after seed: the second one wins
    '{ACT_SEED, 32'h0000_0001, 1'b0, 32'h0000_0000},
    '{ACT_SEED, 32'h0000_0002, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    // top bit alone
    '{ACT_SEED, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ACT_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  logic clk;
  logic rst;

  mtg_in_if  cmd_if ();
  mtg_out_if rnd_if ();

  mersenne_twister_generator u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rnd (rnd_if)
  );

  // predictor state: its own copy of the word table and read position
  logic [WORD_W-1:0]  mt_words [WORDS];
  logic [INDEX_W-1:0] mt_pos;

  // tempered values still owed by the block, oldest first
  logic [WORD_W-1:0] pending_values [$];

  int error_count = 0;
  int cmd_beats   = 0;
  int cycles      = 0;
  bit reset_done  = 1'b0;
  bit hold_rnd    = 1'b0;  // asks the rnd side for one long stall
  bit pause_req   = 1'b0;  // asks the cmd side to wait until nothing is owed
  bit cmd_steady  = 1'b0;  // cmd side offers beats with no gaps while set
  bit rnd_steady  = 1'b0;  // rnd side keeps ready up while set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d values still owed", $time, cycles,
               pending_values.size());
      $display("tb failed");
      $finish;
    end
  end

  // init recurrence over the whole table; the read position goes back to zero
  function automatic void seed_words(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] p;
    mt_words[0] = s;
    for (int k = 1; k < WORDS; k++) begin
      p = mt_words[k-1];
      mt_words[k] = INIT_MULT * (p ^ (p >> 30)) + WORD_W'(k);
    end
    mt_pos = '0;
  endfunction

  // regenerate all words in place, in index order
  function automatic void twist_words();
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] w;
    for (int k = 0; k < WORDS; k++) begin
      y = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % WORDS] & LOWER_MASK);
      w = mt_words[(k + SHIFT) % WORDS] ^ (y >> 1);
      if (y[0]) w ^= MATRIX;
      mt_words[k] = w;
    end
  endfunction

  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y ^= y >> 11;
    y ^= (y << 7) & TEMPER_B;
    y ^= (y << 15) & TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  // value of the next draw; twists first whenever the position is at zero
  function automatic logic [WORD_W-1:0] next_draw();
    logic [WORD_W-1:0] word;
    if (mt_pos >= INDEX_W'(WORDS)) mt_pos = '0;
    if (mt_pos == '0) twist_words();
    word = mt_words[mt_pos];
    mt_pos = (mt_pos == INDEX_W'(WORDS - 1)) ? '0 : mt_pos + 1'b1;
    return temper_word(word);
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // offer one cmd beat and run the predictor once it is taken
  // valid stays high into the next beat when there is no gap, so it is
  // never lowered and raised in the same step
  task automatic send_beat(input logic act, input logic [WORD_W-1:0] sd,
                           input logic typed, input logic [WORD_W-1:0] typed_val);
    int gap;
    logic took;
    logic [WORD_W-1:0] drawn;
    gap = cmd_steady ? 0 : int'($urandom_range(0, 10));
    if ($urandom_range(0, 29) == 0) cmd_steady = !cmd_steady;
    if (pause_req) begin
      // hold back until every owed value has come out
      cmd_if.valid <= 1'b0;
      @(posedge clk);
      while (pending_values.size() != 0) @(posedge clk);
      pause_req = 1'b0;
    end else if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.action <= act;
    cmd_if.seed   <= sd;
    // ready is sampled mid-cycle, where it is settled for the coming edge
    do begin
      @(negedge clk);
      took = cmd_if.ready;
      @(posedge clk);
    end while (!took);
    cmd_beats++;
    if (act == ACT_SEED) begin
      seed_words(sd);
    end else begin
      drawn = next_draw();
      pending_values.push_back(typed ? typed_val : drawn);
    end
    if (cmd_beats == HOLD_AT) hold_rnd = 1'b1;
    if (cmd_beats == PAUSE_AT) pause_req = 1'b1;
  endtask

  // rnd side: random stalls per beat, one long stall on request, checks each value
  initial begin
    int gap;
    logic got;
    logic [WORD_W-1:0] seen;
    logic [WORD_W-1:0] want;
    rnd_if.ready <= 1'b0;
    while (!reset_done) @(posedge clk);
    forever begin
      if (hold_rnd) begin
        // long stall: the result register fills and cmd backs up behind it
        gap = HOLD_CYCLES;
        hold_rnd = 1'b0;
      end else begin
        gap = rnd_steady ? 0 : int'($urandom_range(0, 10));
        if ($urandom_range(0, 29) == 0) rnd_steady = !rnd_steady;
      end
      if (gap > 0) begin
        rnd_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rnd_if.ready <= 1'b1;
      do begin
        @(negedge clk);
        got  = rnd_if.valid;
        seen = rnd_if.value;
        @(posedge clk);
      end while (!got);
      if (pending_values.size() == 0) begin
        $display("%0t: value beat with nothing owed, expected none, got %08h", $time, seen);
        error_count++;
      end else begin
        want = pending_values.pop_front();
        if (seen !== want) begin
          $display("%0t: value mismatch, expected %08h, got %08h", $time, want, seen);
          error_count++;
        end
      end
    end
  end

  // reset, directed table, random segments, drain and verdict
  initial begin
    int sent;
    int run_len;
    rst           <= 1'b1;
    cmd_if.valid  <= 1'b0;
    cmd_if.action <= ACT_SEED;
    cmd_if.seed   <= '0;
    for (int k = 0; k < WORDS; k++) mt_words[k] = '0;
    mt_pos = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    foreach (PLAN[r]) send_beat(PLAN[r].act, PLAN[r].sd, PLAN[r].typed, PLAN[r].want);

    // random part: mostly a seed followed by a run of draws; some runs pass the
    // 624-word boundary so the table is twisted again mid-run, some runs carry on
    // without a new seed, and empty runs give back-to-back seeds
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        send_beat(ACT_SEED, pick_seed(), 1'b0, '0);
        sent++;
      end
      run_len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(615, 640))
                                            : int'($urandom_range(0, 60));
      for (int d = 0; d < run_len && sent < RAND_ITEMS; d++) begin
        send_beat(ACT_DRAW, $urandom(), 1'b0, '0);
        sent++;
      end
    end
    cmd_if.valid <= 1'b0;

    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_values.size() != 0) begin
      $display("%0t: %0d values never came out", $time, pending_values.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mtg_pkg.sv
rtl/core/mtg_if.sv
rtl/core/mtg_cell.sv
rtl/core/mtg_feedback.sv
rtl/core/mersenne_twister_generator.sv
tb/tb.sv
